@@ sv/pfnl_pkg.sv @@
package pfnl_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_FACE = 2'd0,
    OP_LOAD_FORB = 2'd1,
    OP_RUN       = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_COMPARE,
    ST_FORBID,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;
    logic load;
    logic cmp;
    logic cmp_self_mark;
    logic rotate;
  } cell_ctrl_t;

endpackage

@@ sv/pfnl_ram.sv @@
module pfnl_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/pfnl_cell.sv @@
// One cell holds one intersection, its order tag and its keep mark. During the
// compare phase a probe value with its tag circulates past the cells; each
// cell drops itself when it is covered by the probe.
module pfnl_cell
  import pfnl_pkg::*;
#(
  parameter int FaceBits = 64,
  parameter int TagW     = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [FaceBits-1:0] load_face,
  input  logic [TagW-1:0]     load_tag,
  input  logic                load_used,
  input  logic [FaceBits-1:0] prev_face,
  input  logic [TagW-1:0]     prev_tag,
  input  logic                prev_used,
  input  logic                prev_keep,
  input  logic [FaceBits-1:0] probe,
  input  logic                probe_used,
  input  logic [TagW-1:0]     probe_tag,
  output logic [FaceBits-1:0] face,
  output logic [TagW-1:0]     tag,
  output logic                used,
  output logic                keep
);

  logic [FaceBits-1:0] face_r;
  logic [TagW-1:0]     tag_r;
  logic                used_r, keep_r, keep_nxt;
  logic                covered;

  assign covered = ((face_r & ~probe) == '0) && probe_used && (probe_tag != tag_r) &&
                   ((probe_tag < tag_r) || (face_r != probe));

  // The ring rotates on every compare step, so the mark leaves with the face
  // and the neighbour receives it already cleared when the probe covers it.
  always_comb begin
    keep_nxt = keep_r;
    if (ctrl.clear) begin
      keep_nxt = 1'b0;
    end else if (ctrl.load) begin
      keep_nxt = load_used;
    end else if (ctrl.rotate) begin
      keep_nxt = prev_keep;
    end else if (ctrl.cmp_self_mark && probe_used && ((face_r & ~probe) == '0)) begin
      keep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      keep_r <= 1'b0;
    end else begin
      keep_r <= keep_nxt;
      if (ctrl.clear) begin
        used_r <= 1'b0;
      end else if (ctrl.load) begin
        used_r <= load_used;
      end else if (ctrl.rotate) begin
        used_r <= prev_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      face_r <= load_face;
      tag_r  <= load_tag;
    end else if (ctrl.rotate) begin
      face_r <= prev_face;
      tag_r  <= prev_tag;
    end
  end

  assign face = face_r;
  assign tag  = tag_r;
  assign used = used_r;
  assign keep = keep_r && !(ctrl.cmp && covered);

endmodule

@@ sv/polytope_face_next_level.sv @@
// Next-level face engine. Words arrive on the in_ channel: op 0 writes a face
// bitset to slot in_slot, op 1 a forbidden bitset, op 2 starts a run on the
// faces 0..in_face_count-1 with in_pivot and the first in_forbidden_count
// forbidden sets. Loads give no result word.
// A run reads every face from the face memory (one a cycle), fills a ring of
// MAX_FACES-1 cells with the intersections, then rotates the ring once per
// compare step: each rotation step shows one intersection to all cells at
// once. Each forbidden set is then read one a cycle and shown to all cells.
// Kept faces leave from the head of the ring, one per rotation. The loop over
// the ring and the single read port of each memory set the length of a run.
// Results leave as words on the out_ channel in position order; out_last marks
// the final word of a run. A run keeping nothing gives one word with
// out_valid_face low and out_last high. A stalled receiver holds the ring;
// no input word is taken while a run is in progress. Reset (rst_n low,
// synchronous) returns the sequencer to idle and clears the cells' marks;
// the face and forbidden memories keep their contents and read as undefined
// until written.
module polytope_face_next_level
  import pfnl_pkg::*;
#(
  parameter int MAX_FACES = 64,
  parameter int FACE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_slot,
  input  logic [63:0] in_face_bits,
  input  logic [6:0]  in_face_count,
  input  logic [5:0]  in_pivot,
  input  logic [6:0]  in_forbidden_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_out_face,
  output logic [5:0]  out_out_position,
  output logic        out_valid_face,
  output logic        out_last
);

  localparam int NC   = MAX_FACES - 1;
  localparam int AW   = $clog2(MAX_FACES);
  localparam int CW   = $clog2(MAX_FACES + 1);
  localparam int TagW = CW;

  state_t state_r, state_nxt;
  logic [CW-1:0] nf_r, nb_r, cnt_r, cnt_nxt;
  logic [AW-1:0] pv_r;
  logic [FACE_BITS-1:0] pivot_face_r;
  logic          in_acc, run_ok;
  logic [6:0]    nf_sat, nb_sat;
  logic [TagW-1:0] wr_tag_r;
  logic          rd_phase_r;
  cell_ctrl_t    ctrl;

  logic [FACE_BITS-1:0] face_rd, forb_rd;
  logic [AW-1:0]        face_ra, forb_ra;
  logic                 face_vld_r, forb_vld_r;
  logic [CW-1:0]        face_idx_r;

  logic [FACE_BITS-1:0] c_face [NC];
  logic [TagW-1:0]      c_tag  [NC];
  logic                 c_used [NC];
  logic                 c_keep [NC];
  logic [FACE_BITS-1:0] probe;
  logic                 probe_used;
  logic [TagW-1:0]      probe_tag;
  logic                 any_kept_r;
  logic [FACE_BITS-1:0] load_face;
  logic                 load_en;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !out_valid;
  assign nf_sat = (in_face_count > 7'(MAX_FACES)) ? 7'(MAX_FACES) : in_face_count;
  assign nb_sat = (in_forbidden_count > 7'(MAX_FACES)) ? 7'(MAX_FACES) :
                  in_forbidden_count;
  assign run_ok = (nf_sat >= 7'd2) && ({1'b0, in_pivot} < nf_sat);

  pfnl_ram #(.Width(FACE_BITS), .Depth(MAX_FACES)) u_face_ram (
    .clk, .wr_en(in_acc && in_op == OP_LOAD_FACE && 32'(in_slot) < MAX_FACES),
    .wr_addr(in_slot[AW-1:0]), .wr_data(in_face_bits[FACE_BITS-1:0]),
    .rd_addr(face_ra), .rd_data(face_rd));

  pfnl_ram #(.Width(FACE_BITS), .Depth(MAX_FACES)) u_forb_ram (
    .clk, .wr_en(in_acc && in_op == OP_LOAD_FORB && 32'(in_slot) < MAX_FACES),
    .wr_addr(in_slot[AW-1:0]), .wr_data(in_face_bits[FACE_BITS-1:0]),
    .rd_addr(forb_ra), .rd_data(forb_rd));

  // Gather: first read the pivot (captured while rd_phase is set), then faces 0..nf-1.
  assign face_ra = (state_r == ST_IDLE) ? in_pivot[AW-1:0] : cnt_r[AW-1:0];
  assign forb_ra = cnt_r[AW-1:0];

  // The ring shifts in at cell 0 while gathering; the load mux feeds cell 0.
  assign load_face = face_rd & pivot_face_r;
  assign load_en   = (state_r == ST_GATHER) && face_vld_r &&
                     (face_idx_r[AW-1:0] != pv_r);

  // Probe is the head cell during compare, the forbidden word during forbid.
  always_comb begin
    probe      = c_face[NC-1];
    probe_used = c_used[NC-1];
    probe_tag  = c_tag[NC-1];
  end

  always_comb begin
    ctrl = '0;
    ctrl.clear = in_acc && in_op == OP_RUN;
    ctrl.load  = 1'b0;
    ctrl.rotate = load_en;
    ctrl.cmp   = (state_r == ST_COMPARE);
    ctrl.cmp_self_mark = (state_r == ST_FORBID) && forb_vld_r;
    if (state_r == ST_COMPARE) ctrl.rotate = 1'b1;
    if (state_r == ST_EMIT && (!out_valid || out_ready)) ctrl.rotate = 1'b1;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      logic [FACE_BITS-1:0] pf, pb;
      logic [TagW-1:0]      pt;
      logic                 pu, pk, pbu;
      if (gi == 0) begin : g_head
        assign pf = load_en ? load_face : c_face[NC-1];
        assign pt = load_en ? wr_tag_r : c_tag[NC-1];
        assign pu = load_en ? 1'b1 : c_used[NC-1];
        assign pk = load_en ? 1'b1 : c_keep[NC-1];
      end else begin : g_body
        assign pf = c_face[gi-1];
        assign pt = c_tag[gi-1];
        assign pu = c_used[gi-1];
        assign pk = c_keep[gi-1];
      end
      assign pb  = (state_r == ST_FORBID) ? forb_rd : probe;
      assign pbu = (state_r == ST_FORBID) ? 1'b1 : probe_used;
      pfnl_cell #(.FaceBits(FACE_BITS), .TagW(TagW)) u_cell (
        .clk, .rst_n, .ctrl,
        .load_face('0), .load_tag('0), .load_used(1'b0),
        .prev_face(pf), .prev_tag(pt), .prev_used(pu), .prev_keep(pk),
        .probe(pb), .probe_used(pbu),
        .probe_tag((state_r == ST_FORBID) ? {TagW{1'b1}} : probe_tag),
        .face(c_face[gi]), .tag(c_tag[gi]), .used(c_used[gi]), .keep(c_keep[gi]));
    end
  endgenerate

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_face_r;
  logic [5:0]       out_pos_r;
  logic             out_vf_r, out_last_r;
  logic             emit_take;

  assign out_valid        = out_valid_r;
  assign out_out_face     = out_face_r;
  assign out_out_position = out_pos_r;
  assign out_valid_face   = out_vf_r;
  assign out_last         = out_last_r;
  assign emit_take = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // A taken word frees the register unless a new word replaces it at once.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit_take && c_used[NC-1] && c_keep[NC-1]) out_valid_nxt = 1'b1;
    if (state_r == ST_EMPTY && (!out_valid_r || out_ready)) out_valid_nxt = 1'b1;
  end

  // Remaining kept faces ahead of the head, used for the last marker.
  logic more_kept;
  always_comb begin
    more_kept = 1'b0;
    for (int i = 0; i < NC - 1; i++) begin
      if (c_used[i] && c_keep[i] && (c_tag[i] > c_tag[NC-1])) more_kept = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == OP_RUN) begin
          cnt_nxt   = '0;
          state_nxt = run_ok ? ST_GATHER : ST_EMPTY;
        end
      end
      ST_GATHER: begin
        if (cnt_r < nf_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!face_vld_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (cnt_r == CW'(NC - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FORBID;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FORBID: begin
        if (cnt_r < nb_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!forb_vld_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_take) begin
          if (cnt_r == CW'(NC - 1)) begin
            state_nxt = (any_kept_r || (c_used[NC-1] && c_keep[NC-1])) ? ST_IDLE : ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_EMPTY: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      face_vld_r  <= 1'b0;
      forb_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      any_kept_r  <= 1'b0;
      rd_phase_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      face_vld_r  <= (state_r == ST_GATHER) && (cnt_r < nf_r);
      forb_vld_r  <= (state_r == ST_FORBID) && (cnt_r < nb_r);
      rd_phase_r  <= (state_r == ST_IDLE) && in_acc && in_op == OP_RUN;
      out_valid_r <= out_valid_nxt;
      if (ctrl.clear) any_kept_r <= 1'b0;
      if (emit_take && c_used[NC-1] && c_keep[NC-1]) any_kept_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_phase_r) pivot_face_r <= face_rd;
    if (in_acc && in_op == OP_RUN) begin
      nf_r     <= nf_sat[CW-1:0];
      nb_r     <= nb_sat[CW-1:0];
      pv_r     <= in_pivot[AW-1:0];
      wr_tag_r <= '0;
    end
    face_idx_r <= cnt_r;
    if (load_en) wr_tag_r <= wr_tag_r + 1'b1;
    if (emit_take && c_used[NC-1] && c_keep[NC-1]) begin
      out_face_r <= 64'(c_face[NC-1]);
      out_pos_r  <= 6'(c_tag[NC-1]);
      out_vf_r   <= 1'b1;
      out_last_r <= !more_kept;
    end
    if (state_r == ST_EMPTY && (!out_valid_r || out_ready)) begin
      out_face_r <= '0;
      out_pos_r  <= '0;
      out_vf_r   <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  // A result word is only produced while a run is being drained.
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT || $past(state_r) == ST_EMPTY))
    else $error("result word outside a run");
  // No input word is taken while a run is active.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input accepted during run");
  // The empty marker always closes its run.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vf_r) |-> out_last_r)
    else $error("empty marker without last");

endmodule
